>>> hw/rtl/http_get_request_parser_defines.svh
// Assertion macros shared by the parser's checker.
`ifndef HTTP_GET_REQUEST_PARSER_DEFINES_SVH
`define HTTP_GET_REQUEST_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle during rst.
`define HGP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hgp check failed");

// Next-cycle implication, sampled on clk, idle during rst.
`define HGP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hgp check failed");

`endif

>>> hw/rtl/hgp_pkg.sv
// Types, constants and byte-matching functions of the HTTP GET request parser.
package hgp_pkg;

  localparam int unsigned MAX_REQUEST_BYTES = 1024;
  localparam int unsigned CNT_W = $clog2(MAX_REQUEST_BYTES + 1);

  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [3:0] METHOD_LEN = 4'd4;
  localparam logic [3:0] VERSION_LEN = 4'd7;
  localparam logic [3:0] WORD_LEN = 4'd10;

  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic KIND_LOCATION = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [3:0] {
    PH_METHOD     = 4'd0,
    PH_LOCATION   = 4'd1,
    PH_VERSION    = 4'd2,
    PH_LINE_REST  = 4'd3,
    PH_LINE_START = 4'd4,
    PH_KEY        = 4'd5,
    PH_VALUE      = 4'd6
  } phase_t;

  typedef enum logic [1:0] {
    VERDICT_ACCEPTED    = 2'd0,
    VERDICT_BAD_REQUEST = 2'd1,
    VERDICT_MALFORMED   = 2'd2
  } verdict_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] pos;
    logic [7:0] held_byte;
    logic       held_valid;
    logic       conn_persist;
    logic       key_match;
    logic       value_match;
    logic       trail;
    logic       decided;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase: PH_METHOD, pos: 4'd0, held_byte: 8'h00, held_valid: 1'b0,
    conn_persist: 1'b0, key_match: 1'b1, value_match: 1'b1, trail: 1'b0,
    decided: 1'b0
  };

  typedef struct packed {
    logic       kind;
    logic [7:0] loc;
    verdict_t   verdict;
    logic       conn_persist;
  } result_t;

  typedef struct packed {
    logic       flag;
    logic [3:0] pos;
    logic       trail;
  } word_match_t;

  function automatic logic [7:0] fold(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
  endfunction

  function automatic logic [7:0] method_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h47;  // G
      4'd1:    c = 8'h45;  // E
      4'd2:    c = 8'h54;  // T
      4'd3:    c = CHAR_SPACE;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] version_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h48;  // H
      4'd1:    c = 8'h54;  // T
      4'd2:    c = 8'h54;  // T
      4'd3:    c = 8'h50;  // P
      4'd4:    c = 8'h2F;  // /
      4'd5:    c = 8'h31;  // 1
      4'd6:    c = 8'h2E;  // .
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "connection" when sel_value is low, "keep-alive" when high
  function automatic logic [7:0] word_char(input logic sel_value, input logic [3:0] idx);
    logic [7:0] c;
    if (sel_value) begin
      case (idx)
        4'd0:    c = 8'h6B;  // k
        4'd1:    c = 8'h65;  // e
        4'd2:    c = 8'h65;  // e
        4'd3:    c = 8'h70;  // p
        4'd4:    c = 8'h2D;  // -
        4'd5:    c = 8'h61;  // a
        4'd6:    c = 8'h6C;  // l
        4'd7:    c = 8'h69;  // i
        4'd8:    c = 8'h76;  // v
        4'd9:    c = 8'h65;  // e
        default: c = 8'h00;
      endcase
    end else begin
      case (idx)
        4'd0:    c = 8'h63;  // c
        4'd1:    c = 8'h6F;  // o
        4'd2:    c = 8'h6E;  // n
        4'd3:    c = 8'h6E;  // n
        4'd4:    c = 8'h65;  // e
        4'd5:    c = 8'h63;  // c
        4'd6:    c = 8'h74;  // t
        4'd7:    c = 8'h69;  // i
        4'd8:    c = 8'h6F;  // o
        4'd9:    c = 8'h6E;  // n
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

  // Trimmed, case-folded compare of one byte against a ten-character word
  function automatic word_match_t match_word(input logic [7:0] b, input logic sel_value,
                                             input logic flag, input logic [3:0] pos,
                                             input logic trail);
    word_match_t r;
    logic started;
    r.flag = flag;
    r.pos = pos;
    r.trail = trail;
    started = (pos != 4'd0) || !flag;
    if (b == CHAR_SPACE) begin
      if (started) r.trail = 1'b1;
    end else if (trail) begin
      r.flag = 1'b0;
    end else if (flag && pos < WORD_LEN && fold(b) == word_char(sel_value, pos)) begin
      r.pos = pos + 4'd1;
    end else begin
      r.flag = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/hgp_out_reg.sv
// Result register that holds one parser result until the downstream side takes it.
module hgp_out_reg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  hgp_pkg::result_t                    res,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // location_byte [7:0], verdict [9:8], conn_persist [10], zero [15:11]
  output logic [hgp_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // result_kind
  output logic                                m_tlast
);

  hgp_pkg::result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = {5'b0, held.conn_persist, held.verdict, held.loc};
  assign m_tlast = held.kind;

endmodule

>>> hw/rtl/hgp_parser_core.sv
// Parser state registers and the one-byte update of the request state machine.
module hgp_parser_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,
  input  logic [7:0]        step_byte,
  input  logic              step_last,
  output logic              res_valid,
  output hgp_pkg::result_t  res
);

  hgp_pkg::state_t            state;
  hgp_pkg::state_t            state_next;
  logic [hgp_pkg::CNT_W-1:0]  bytes_seen;
  logic [hgp_pkg::CNT_W-1:0]  bytes_seen_next;
  logic [hgp_pkg::CNT_W-1:0]  count_inc;
  logic                       last;
  hgp_pkg::word_match_t       mw;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hgp_pkg::STATE_RESET;
      bytes_seen <= '0;
    end else if (step_en) begin
      state <= state_next;
      bytes_seen <= bytes_seen_next;
    end
  end

  always_comb begin
    state_next = state;
    res_valid = 1'b0;
    res = '0;
    mw = '0;
    count_inc = bytes_seen + 1'b1;
    last = step_last || (count_inc == hgp_pkg::CNT_W'(hgp_pkg::MAX_REQUEST_BYTES));

    if (!state.decided) begin
      if (step_byte == hgp_pkg::CHAR_NL) begin
        state_next.held_valid = 1'b0;
        unique case (state.phase)
          hgp_pkg::PH_METHOD, hgp_pkg::PH_LOCATION, hgp_pkg::PH_VERSION: begin
            res_valid = 1'b1;
            res.kind = hgp_pkg::KIND_VERDICT;
            res.verdict = hgp_pkg::VERDICT_BAD_REQUEST;
            state_next.decided = 1'b1;
          end
          hgp_pkg::PH_LINE_REST: begin
            state_next.phase = hgp_pkg::PH_LINE_START;
            state_next.pos = 4'd0;
            state_next.key_match = 1'b1;
            state_next.value_match = 1'b1;
            state_next.trail = 1'b0;
          end
          hgp_pkg::PH_LINE_START: begin
            // blank line: accept
            res_valid = 1'b1;
            res.kind = hgp_pkg::KIND_VERDICT;
            res.verdict = hgp_pkg::VERDICT_ACCEPTED;
            res.conn_persist = state.conn_persist;
            state_next.decided = 1'b1;
          end
          hgp_pkg::PH_KEY: begin
            res_valid = 1'b1;
            res.kind = hgp_pkg::KIND_VERDICT;
            res.verdict = hgp_pkg::VERDICT_MALFORMED;
            state_next.decided = 1'b1;
          end
          hgp_pkg::PH_VALUE: begin
            if (state.key_match) begin
              state_next.conn_persist = state.value_match && (state.pos == hgp_pkg::WORD_LEN);
            end
            state_next.phase = hgp_pkg::PH_LINE_START;
            state_next.pos = 4'd0;
            state_next.key_match = 1'b1;
            state_next.value_match = 1'b1;
            state_next.trail = 1'b0;
          end
          default: begin
          end
        endcase
      end else if (!last) begin
        if (state.held_valid) begin
          unique case (state.phase)
            hgp_pkg::PH_METHOD: begin
              if (state.pos < hgp_pkg::METHOD_LEN &&
                  state.held_byte == hgp_pkg::method_char(state.pos)) begin
                state_next.pos = state.pos + 4'd1;
                if (state.pos + 4'd1 == hgp_pkg::METHOD_LEN) begin
                  state_next.phase = hgp_pkg::PH_LOCATION;
                  state_next.pos = 4'd0;
                end
              end else begin
                res_valid = 1'b1;
                res.kind = hgp_pkg::KIND_VERDICT;
                res.verdict = hgp_pkg::VERDICT_BAD_REQUEST;
                state_next.decided = 1'b1;
              end
            end
            hgp_pkg::PH_LOCATION: begin
              if (state.held_byte == hgp_pkg::CHAR_SPACE) begin
                state_next.phase = hgp_pkg::PH_VERSION;
                state_next.pos = 4'd0;
              end else begin
                res_valid = 1'b1;
                res.kind = hgp_pkg::KIND_LOCATION;
                res.loc = state.held_byte;
              end
            end
            hgp_pkg::PH_VERSION: begin
              if (state.pos < hgp_pkg::VERSION_LEN &&
                  state.held_byte == hgp_pkg::version_char(state.pos)) begin
                state_next.pos = state.pos + 4'd1;
                if (state.pos + 4'd1 == hgp_pkg::VERSION_LEN) begin
                  state_next.phase = hgp_pkg::PH_LINE_REST;
                end
              end else begin
                res_valid = 1'b1;
                res.kind = hgp_pkg::KIND_VERDICT;
                res.verdict = hgp_pkg::VERDICT_BAD_REQUEST;
                state_next.decided = 1'b1;
              end
            end
            hgp_pkg::PH_LINE_REST: begin
            end
            hgp_pkg::PH_LINE_START, hgp_pkg::PH_KEY: begin
              state_next.phase = hgp_pkg::PH_KEY;
              if (state.held_byte == hgp_pkg::CHAR_COLON) begin
                state_next.key_match = state.key_match && (state.pos == hgp_pkg::WORD_LEN);
                state_next.pos = 4'd0;
                state_next.value_match = 1'b1;
                state_next.trail = 1'b0;
                state_next.phase = hgp_pkg::PH_VALUE;
              end else begin
                mw = hgp_pkg::match_word(state.held_byte, 1'b0, state.key_match,
                                         state.pos, state.trail);
                state_next.key_match = mw.flag;
                state_next.pos = mw.pos;
                state_next.trail = mw.trail;
              end
            end
            hgp_pkg::PH_VALUE: begin
              mw = hgp_pkg::match_word(state.held_byte, 1'b1, state.value_match,
                                       state.pos, state.trail);
              state_next.value_match = mw.flag;
              state_next.pos = mw.pos;
              state_next.trail = mw.trail;
            end
            default: begin
            end
          endcase
        end
        state_next.held_byte = step_byte;
        state_next.held_valid = 1'b1;
      end

      // unterminated end of request
      if (last && !state_next.decided) begin
        res_valid = 1'b1;
        res = '0;
        res.kind = hgp_pkg::KIND_VERDICT;
        res.verdict = (state_next.phase <= hgp_pkg::PH_LINE_REST) ?
                      hgp_pkg::VERDICT_BAD_REQUEST : hgp_pkg::VERDICT_MALFORMED;
      end
    end

    if (last) begin
      state_next = hgp_pkg::STATE_RESET;
      bytes_seen_next = '0;
    end else begin
      bytes_seen_next = count_inc;
    end
  end

endmodule

>>> hw/rtl/http_get_request_parser.sv
// A byte waits in the input register; as it advances, one parser step loads its result.
// A location byte is held until the byte after it arrives, so its result waits for that byte.
// Throughput: one request byte per cycle while the result register is free or being taken.
// The input register empties whenever the result register is free or being taken.
// Reset: synchronous rst clears both register stages and the parser; no clearing pass.
// Top level of the HTTP GET request parser: input register, parser core, result register.
module http_get_request_parser (
  input  logic                                clk,
  input  logic                                rst,
  // request byte stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // data_byte [7:0]
  input  logic [hgp_pkg::IN_TDATA_W-1:0]      s_tdata,
  // end_of_request
  input  logic                                s_tlast,
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // location_byte [7:0], verdict [9:8], conn_persist [10], zero [15:11]
  output logic [hgp_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // result_kind: 0 location byte, 1 verdict (last of a request)
  output logic                                m_tlast
);

  logic                  in_valid;
  logic [7:0]            in_byte;
  logic                  in_last;
  logic                  out_free;
  logic                  advance;
  logic                  res_valid;
  hgp_pkg::result_t      res;

  // The result register is free when empty or when its result leaves this cycle.
  assign out_free = !m_tvalid || m_tready;
  // Advance the held byte through the parser whenever its result has a place to go.
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Input register: hold one request byte until the parser takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata[7:0];
      in_last <= s_tlast;
    end
  end

  // Parser state machine: one byte per advance, at most one result.
  hgp_parser_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step_en   (advance),
    .step_byte (in_byte),
    .step_last (in_last),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register: load only bytes that produce a result; drop the rest.
  hgp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res_valid),
    .res      (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> hw/rtl/hgp_checker.sv
// Port-level checker for the HTTP GET request parser, bound to the top level.
`include "http_get_request_parser_defines.svh"

module hgp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [hgp_pkg::IN_TDATA_W-1:0]    s_tdata,
  input logic                              s_tlast,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [hgp_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input logic                              m_tlast
);

  logic [hgp_pkg::OUT_TDATA_W:0] out_word;
  logic                          verdict_ok;
  logic                          accepted;

  assign out_word = {m_tlast, m_tdata};
  assign verdict_ok = m_tdata[7:0] == 8'h00 && m_tdata[15:11] == 5'b0 &&
                      m_tdata[9:8] <= hgp_pkg::VERDICT_MALFORMED;
  assign accepted = m_tlast && m_tdata[9:8] == hgp_pkg::VERDICT_ACCEPTED;

  // A stalled result holds.
  `HGP_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(out_word))

  // A location result carries no verdict, no keep-alive and zero padding.
  `HGP_ASSERT_NOW(a_loc_clean, m_tvalid && !m_tlast, m_tdata[15:8] == 8'h00)

  // A verdict carries no location byte and a defined code.
  `HGP_ASSERT_NOW(a_verdict_code, m_tvalid && m_tlast, verdict_ok)

  // Keep-alive only comes with an accepted request.
  `HGP_ASSERT_NOW(a_persist_accept, m_tvalid && m_tdata[10], accepted)

endmodule

bind http_get_request_parser hgp_checker u_hgp_checker (.*);
